@@ sv/htl_pkg.sv @@
// Shared types, constants and register codes of the timer, line and interrupt unit.
package htl_pkg;

  localparam int unsigned CplW     = 10;
  localparam int unsigned LineW    = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ElapsedW = 6;
  localparam int unsigned TaccW    = 9;
  localparam int unsigned AddrW    = 16;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  localparam logic [CplW-1:0]  CplReset    = 10'd456;
  localparam logic [LineW-1:0] WrapReset   = 8'd153;
  localparam logic [LineW-1:0] VblankReset = 8'd144;

  localparam logic [1:0] RegCyclesPerLine = 2'd0;
  localparam logic [1:0] RegLineWrap      = 2'd1;
  localparam logic [1:0] RegVblankAfter   = 2'd2;

  localparam logic [1:0] ModeDiv256 = 2'd0;
  localparam logic [1:0] ModeDiv4   = 2'd1;
  localparam logic [1:0] ModeDiv16  = 2'd2;
  localparam logic [1:0] ModeDiv64  = 2'd3;

  localparam int unsigned TimerEnBit = 2;
  localparam int unsigned IrqVblankBit = 0;
  localparam int unsigned IrqTimerBit  = 2;
  localparam int unsigned IrqJoypadBit = 4;

  localparam logic [1:0] SrcJoypad = 2'd0;
  localparam logic [1:0] SrcTimer  = 2'd1;
  localparam logic [1:0] SrcVblank = 2'd2;

  typedef struct packed {
    logic [CplW-1:0]  cycles_per_line;
    logic [LineW-1:0] line_wrap;
    logic [LineW-1:0] vblank_after;
  } cfg_t;

  typedef struct packed {
    logic [CplW-1:0]   line_cycle_accum;
    logic [TaccW-1:0]  timer_cycle_accum;
    logic [1:0]        last_timer_mode;
    logic [CountW-1:0] last_counter;
    logic [LineW-1:0]  last_line;
    logic [7:0]        last_joypad;
  } state_t;

  typedef struct packed {
    logic [7:0]          joypad_value;
    logic [AddrW-1:0]    stack_pointer;
    logic [AddrW-1:0]    program_counter;
    logic                master_enable;
    logic [LineW-1:0]    line_in;
    logic [4:0]          enable_mask;
    logic [CountW-1:0]   counter_in;
    logic [7:0]          reload_value;
    logic [2:0]          timer_control;
    logic [ElapsedW-1:0] elapsed_cycles;
  } item_t;

  typedef struct packed {
    logic             master_enable_out;
    logic [AddrW-1:0] push_data;
    logic [AddrW-1:0] new_stack_pointer;
    logic [1:0]       irq_source;
    logic             irq_taken;
    logic [LineW-1:0] line_out;
    logic [CountW-1:0] counter_out;
  } result_t;

endpackage

@@ sv/htl_cfg.sv @@
// Configuration registers of the timer, line and interrupt unit behind an APB-style port.
module htl_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [htl_pkg::PaddrW-1:0]  paddr,
  input  logic [htl_pkg::PdataW-1:0]  pwdata,
  output logic [htl_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  output htl_pkg::cfg_t               cfg_o
);
  import htl_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegCyclesPerLine: cfg_d.cycles_per_line = pwdata[CplW-1:0];
        RegLineWrap:      cfg_d.line_wrap       = pwdata[LineW-1:0];
        RegVblankAfter:   cfg_d.vblank_after    = pwdata[LineW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCyclesPerLine: prdata = PdataW'(cfg_q.cycles_per_line);
      RegLineWrap:      prdata = PdataW'(cfg_q.line_wrap);
      RegVblankAfter:   prdata = PdataW'(cfg_q.vblank_after);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycles_per_line <= CplReset;
      cfg_q.line_wrap       <= WrapReset;
      cfg_q.vblank_after    <= VblankReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/htl_step.sv @@
// Single-step update logic: line advance, timer count and interrupt dispatch.
module htl_step (
  input  htl_pkg::item_t   item_i,
  input  htl_pkg::state_t  state_i,
  input  htl_pkg::cfg_t    cfg_i,
  output htl_pkg::state_t  state_o,
  output htl_pkg::result_t result_o
);
  import htl_pkg::*;

  logic [LineW-1:0]  line_base;
  logic [CplW:0]     lacc_sum;
  logic [CplW:0]     lacc_sub;
  logic              line_adv;
  logic [LineW-1:0]  line_inc;
  logic [LineW-1:0]  line_new;

  logic [1:0]        mode;
  logic              mode_chg;
  logic              timer_en;
  logic [TaccW-1:0]  tacc_base;
  logic [TaccW:0]    tacc_sum;
  logic [TaccW:0]    tsteps;
  logic [TaccW:0]    trem;
  logic [CountW-1:0] tcount_adv;
  logic [CountW-1:0] tcount_fin;
  logic              twrap;

  logic              req_joy;
  logic              req_tmr;
  logic              req_vbl;
  logic              taken;

  always_comb begin
    line_base = (item_i.line_in != state_i.last_line) ? '0 : item_i.line_in;
    lacc_sum  = {1'b0, state_i.line_cycle_accum} + (CplW+1)'(item_i.elapsed_cycles);
    line_adv  = lacc_sum >= {1'b0, cfg_i.cycles_per_line};
    lacc_sub  = line_adv ? lacc_sum - {1'b0, cfg_i.cycles_per_line} : lacc_sum;
    line_inc  = line_base + LineW'(1);
    if (line_adv) begin
      line_new = (line_inc == cfg_i.line_wrap) ? '0 : line_inc;
    end else begin
      line_new = line_base;
    end
  end

  always_comb begin
    mode      = item_i.timer_control[1:0];
    timer_en  = item_i.timer_control[TimerEnBit];
    mode_chg  = mode != state_i.last_timer_mode;
    tacc_base = mode_chg ? '0 : state_i.timer_cycle_accum;
    tacc_sum  = {1'b0, tacc_base} + (TaccW+1)'(item_i.elapsed_cycles);
    case (mode)
      ModeDiv256: begin
        tsteps = tacc_sum >> 8;
        trem   = tacc_sum & (TaccW+1)'(255);
      end
      ModeDiv4: begin
        tsteps = tacc_sum >> 2;
        trem   = tacc_sum & (TaccW+1)'(3);
      end
      ModeDiv16: begin
        tsteps = tacc_sum >> 4;
        trem   = tacc_sum & (TaccW+1)'(15);
      end
      ModeDiv64: begin
        tsteps = tacc_sum >> 6;
        trem   = tacc_sum & (TaccW+1)'(63);
      end
      default: begin
        tsteps = '0;
        trem   = '0;
      end
    endcase
    tcount_adv = timer_en ? item_i.counter_in + tsteps[CountW-1:0] : item_i.counter_in;
    twrap      = state_i.last_counter > tcount_adv;
    tcount_fin = twrap ? tcount_adv + item_i.reload_value : tcount_adv;
  end

  always_comb begin
    req_joy = (item_i.joypad_value != state_i.last_joypad)
              & item_i.enable_mask[IrqJoypadBit] & item_i.master_enable;
    req_tmr = twrap & item_i.enable_mask[IrqTimerBit] & item_i.master_enable;
    req_vbl = (line_new > cfg_i.vblank_after)
              & item_i.enable_mask[IrqVblankBit] & item_i.master_enable;
    taken   = req_joy | req_tmr | req_vbl;

    result_o.counter_out       = tcount_fin;
    result_o.line_out          = line_new;
    result_o.irq_taken         = taken;
    if (req_joy) begin
      result_o.irq_source = SrcJoypad;
    end else if (req_tmr) begin
      result_o.irq_source = SrcTimer;
    end else if (req_vbl) begin
      result_o.irq_source = SrcVblank;
    end else begin
      result_o.irq_source = SrcJoypad;
    end
    result_o.new_stack_pointer = taken ? item_i.stack_pointer - AddrW'(2)
                                       : item_i.stack_pointer;
    result_o.push_data         = taken ? item_i.program_counter : '0;
    result_o.master_enable_out = item_i.master_enable & ~taken;
  end

  always_comb begin
    state_o.line_cycle_accum  = lacc_sub[CplW] ? '1 : lacc_sub[CplW-1:0];
    state_o.last_line         = line_adv ? line_new : state_i.last_line;
    state_o.last_timer_mode   = mode;
    state_o.timer_cycle_accum = timer_en ? trem[TaccW-1:0] : tacc_base;
    state_o.last_counter      = tcount_fin;
    state_o.last_joypad       = item_i.joypad_value;
  end

endmodule

@@ sv/handheld_timer_line_irq_unit.sv @@
// Top level of the timer, scanline and interrupt unit with stream ports and APB registers.
//
// Each input transaction is one executed CPU step; the unit returns exactly one result
// transaction for it. A step is captured in an input register, goes through the update
// logic and lands in a result register, where the result becomes valid; while the output
// is not stalled, the unit takes one transaction every cycle.
// The line and timer state is written at the edge where a step moves into the result
// register, which lets the following step use it in the next cycle. Back-pressure on
// the output stalls both registers; the input stays ready while either one has room.
// Registers: cycles_per_line at 0x0, line_wrap at 0x4, vblank_after at 0x8; they are
// meant to be written while no step is in flight.
module handheld_timer_line_irq_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // elapsed_cycles[5:0], timer_control[8:6], reload_value[16:9], counter_in[24:17],
  // enable_mask[29:25], line_in[37:30], master_enable[38], program_counter[54:39],
  // stack_pointer[70:55], joypad_value[78:71], zero[79]
  input  logic [htl_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // counter_out[7:0], line_out[15:8], irq_taken[16], irq_source[18:17],
  // new_stack_pointer[34:19], push_data[50:35], master_enable_out[51], zero[55:52]
  output logic [htl_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htl_pkg::PaddrW-1:0]    paddr,
  input  logic [htl_pkg::PdataW-1:0]    pwdata,
  output logic [htl_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);
  import htl_pkg::*;

  localparam int unsigned ItemW = $bits(item_t);

  cfg_t    cfg;
  state_t  state_q, state_d;
  item_t   item_q;
  result_t res_d, res_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    out_free;
  logic    advance;
  logic    in_fire;

  htl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  htl_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign advance       = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_t'(s_axis_tdata[ItemW-1:0]);
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(res_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("step moved forward but no result is presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.timer_cycle_accum[TaccW-1] == 1'b0)
    else $error("timer accumulator kept a full period");

endmodule
